// ===== src/wnss_pkg.sv =====
package wnss_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
   localparam int USED_W    = 7;
   localparam int WEIGHT_W  = 16;
   localparam int CSR_IDX_W = 2;
   // max score is below 2^33, so the 36-bit ceiling is never reached
   localparam int SCORE_W   = 33;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_WEIGHT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADING_WEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAG_WEIGHT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_USED_SLOTS     = 2'd3;

   localparam logic [WEIGHT_W-1:0] SPEED_WEIGHT_RST   = 16'd256;
   localparam logic [WEIGHT_W-1:0] HEADING_WEIGHT_RST = 16'd256;
   localparam logic [WEIGHT_W-1:0] FLAG_WEIGHT_RST    = 16'd128;
   localparam logic [USED_W-1:0]   USED_SLOTS_RST     = 7'd0;

   typedef struct packed {
      logic        cmd;
      logic [5:0]  slot;
      logic [15:0] speed;
      logic [15:0] heading;
      logic        sprinting;
      logic        airborne;
      logic        keeper;
      logic        saving;
      logic [15:0] pose_id;
      logic [15:0] anim_id;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] best_pose;
      logic [15:0] best_anim;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  flags;
      logic [15:0] heading;
      logic [15:0] speed;
   } feat_type;

   typedef struct packed {
      logic [15:0] pose_id;
      logic [15:0] anim_id;
   } ids_type;

   typedef struct packed {
      ids_type  ids;
      feat_type feat;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

endpackage

// ===== src/weighted_nearest_sample_search.sv =====
// Load word: written to the table at its slot, one load per cycle while idle, no response word.
// Query word: slots 0 to n - 1 are read and scored, then the response is registered, n = min(used_slots, 64);
// the sample table has one read port, so slots are scored one per cycle.
// One item in flight; the next word can be taken from the cycle in which the response turns valid.
// Reset (synchronous) clears control and sets the weights to their defaults;
// table contents are undefined until each slot is loaded.
module weighted_nearest_sample_search (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  wnss_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output wnss_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [wnss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wnss_pkg::WEIGHT_W-1:0]        csr_wdata
);

   // configuration
   logic [wnss_pkg::WEIGHT_W-1:0] sw_ff, sw_in;
   logic [wnss_pkg::WEIGHT_W-1:0] hw_ff, hw_in;
   logic [wnss_pkg::WEIGHT_W-1:0] fw_ff, fw_in;
   logic [wnss_pkg::USED_W-1:0]   used_ff, used_in;

   // sequencer
   wnss_pkg::state_type        state_ff, state_in;
   logic [wnss_pkg::CNT_W-1:0] n_ff, n_in;
   logic [wnss_pkg::CNT_W-1:0] issue_ff, issue_in;
   wnss_pkg::feat_type         q_ff, q_in;

   // scoring pipeline
   logic                       rd_v_ff, rd_v_in;
   logic                       a_v_ff, a_v_in;
   logic [15:0]                a_ds_ff, a_ds_in;
   logic [15:0]                a_ah_ff, a_ah_in;
   logic [2:0]                 a_cnt_ff, a_cnt_in;
   wnss_pkg::ids_type          a_ids_ff, a_ids_in;
   logic                       b_v_ff, b_v_in;
   logic [31:0]                b_sp_ff, b_sp_in;
   logic [19:0]                b_hd_ff, b_hd_in;
   logic [21:0]                b_fl_ff, b_fl_in;
   wnss_pkg::ids_type          b_ids_ff, b_ids_in;

   // running best
   logic                         have_ff, have_in;
   logic [wnss_pkg::SCORE_W-1:0] best_ff, best_in;
   wnss_pkg::ids_type            best_ids_ff, best_ids_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   wnss_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // table
   logic                                   ram_we;
   logic [wnss_pkg::SLOT_W-1:0]            ram_raddr;
   wnss_pkg::entry_type                    ram_wentry, ram_rentry;
   logic [wnss_pkg::ENTRY_W-1:0]           ram_rdata;

   logic                         req_fire;
   logic                         scan_done;
   logic                         out_free;
   logic [15:0]                  dh;
   logic [3:0]                   fx;
   logic [31:0]                  hd_prod;
   logic [wnss_pkg::SCORE_W-1:0] score;

   assign req_ready = (state_ff == wnss_pkg::S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign ram_we                  = req_fire && (req_data.cmd == wnss_pkg::CMD_LOAD);
   assign ram_wentry.ids.pose_id  = req_data.pose_id;
   assign ram_wentry.ids.anim_id  = req_data.anim_id;
   assign ram_wentry.feat.speed   = req_data.speed;
   assign ram_wentry.feat.heading = req_data.heading;
   assign ram_wentry.feat.flags   = {req_data.saving, req_data.keeper,
                                     req_data.airborne, req_data.sprinting};
   assign ram_raddr               = issue_ff[wnss_pkg::SLOT_W-1:0];
   assign ram_rentry              = wnss_pkg::entry_type'(ram_rdata);

   wnss_ram #(
      .WIDTH(wnss_pkg::ENTRY_W),
      .DEPTH(wnss_pkg::MAX_SLOTS)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(req_data.slot),
      .wdata(ram_wentry),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      sw_in   = sw_ff;
      hw_in   = hw_ff;
      fw_in   = fw_ff;
      used_in = used_ff;
      if (csr_we) begin
         unique case (csr_index)
            wnss_pkg::CSR_SPEED_WEIGHT:   sw_in   = csr_wdata;
            wnss_pkg::CSR_HEADING_WEIGHT: hw_in   = csr_wdata;
            wnss_pkg::CSR_FLAG_WEIGHT:    fw_in   = csr_wdata;
            wnss_pkg::CSR_USED_SLOTS:     used_in = csr_wdata[wnss_pkg::USED_W-1:0];
         endcase
      end
   end

   assign scan_done = (issue_ff == n_ff) && !rd_v_ff && !a_v_ff && !b_v_ff;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      issue_in     = issue_ff;
      q_in         = q_ff;
      rd_v_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         wnss_pkg::S_IDLE: begin
            if (req_fire && (req_data.cmd == wnss_pkg::CMD_QUERY)) begin
               state_in = wnss_pkg::S_SCAN;
               issue_in = '0;
               if (used_ff > wnss_pkg::CNT_W'(wnss_pkg::MAX_SLOTS)) begin
                  n_in = wnss_pkg::CNT_W'(wnss_pkg::MAX_SLOTS);
               end else begin
                  n_in = wnss_pkg::CNT_W'(used_ff);
               end
               q_in.speed   = req_data.speed;
               q_in.heading = req_data.heading;
               q_in.flags   = {req_data.saving, req_data.keeper,
                               req_data.airborne, req_data.sprinting};
            end
         end
         wnss_pkg::S_SCAN: begin
            if (issue_ff != n_ff) begin
               rd_v_in  = 1'b1;
               issue_in = issue_ff + 1'b1;
            end
            if (scan_done) begin
               state_in = wnss_pkg::S_DONE;
            end
         end
         wnss_pkg::S_DONE: begin
            if (out_free) begin
               state_in              = wnss_pkg::S_IDLE;
               rsp_valid_in          = 1'b1;
               rsp_data_in.found     = have_ff;
               rsp_data_in.best_pose = have_ff ? best_ids_ff.pose_id : 16'd0;
               rsp_data_in.best_anim = have_ff ? best_ids_ff.anim_id : 16'd0;
            end
         end
         default: begin
            state_in = wnss_pkg::S_IDLE;
         end
      endcase
   end

   // stage A: speed distance, wrapped heading distance, flag mismatch count
   assign dh = q_ff.heading - ram_rentry.feat.heading;
   assign fx = q_ff.flags ^ ram_rentry.feat.flags;

   always_comb begin
      a_v_in   = rd_v_ff;
      a_ids_in = ram_rentry.ids;
      if (q_ff.speed >= ram_rentry.feat.speed) begin
         a_ds_in = q_ff.speed - ram_rentry.feat.speed;
      end else begin
         a_ds_in = ram_rentry.feat.speed - q_ff.speed;
      end
      // negating 0x8000 leaves 0x8000, which is 180 degrees as wanted
      a_ah_in  = dh[15] ? (16'd0 - dh) : dh;
      a_cnt_in = {2'b00, fx[0]} + {2'b00, fx[1]} + {2'b00, fx[2]} + {2'b00, fx[3]};
   end

   // stage B: weighting
   assign hd_prod = 32'(a_ah_ff) * 32'(hw_ff);

   always_comb begin
      b_v_in   = a_v_ff;
      b_ids_in = a_ids_ff;
      b_sp_in  = 32'(a_ds_ff) * 32'(sw_ff);
      b_hd_in  = hd_prod[31:12];
      b_fl_in  = {19'(a_cnt_ff) * 19'(fw_ff), 3'b000};
   end

   // stage C: sum and keep the first strict minimum
   assign score = wnss_pkg::SCORE_W'(b_sp_ff) + wnss_pkg::SCORE_W'(b_hd_ff)
                + wnss_pkg::SCORE_W'(b_fl_ff);

   always_comb begin
      have_in     = have_ff;
      best_in     = best_ff;
      best_ids_in = best_ids_ff;
      if (req_fire) begin
         have_in = 1'b0;
      end else if (b_v_ff && (!have_ff || (score < best_ff))) begin
         have_in     = 1'b1;
         best_in     = score;
         best_ids_in = b_ids_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff        <= wnss_pkg::SPEED_WEIGHT_RST;
         hw_ff        <= wnss_pkg::HEADING_WEIGHT_RST;
         fw_ff        <= wnss_pkg::FLAG_WEIGHT_RST;
         used_ff      <= wnss_pkg::USED_SLOTS_RST;
         state_ff     <= wnss_pkg::S_IDLE;
         n_ff         <= '0;
         issue_ff     <= '0;
         rd_v_ff      <= 1'b0;
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sw_ff        <= sw_in;
         hw_ff        <= hw_in;
         fw_ff        <= fw_in;
         used_ff      <= used_in;
         state_ff     <= state_in;
         n_ff         <= n_in;
         issue_ff     <= issue_in;
         rd_v_ff      <= rd_v_in;
         a_v_ff       <= a_v_in;
         b_v_ff       <= b_v_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      a_ds_ff     <= a_ds_in;
      a_ah_ff     <= a_ah_in;
      a_cnt_ff    <= a_cnt_in;
      a_ids_ff    <= a_ids_in;
      b_sp_ff     <= b_sp_in;
      b_hd_ff     <= b_hd_in;
      b_fl_ff     <= b_fl_in;
      b_ids_ff    <= b_ids_in;
      best_ff     <= best_in;
      best_ids_ff <= best_ids_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wnss_pkg::S_SCAN) |-> (issue_ff <= n_ff))
      else $error("slot issue count ran past the search length");

   a_n_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wnss_pkg::S_SCAN) |-> (n_ff <= wnss_pkg::CNT_W'(wnss_pkg::MAX_SLOTS)))
      else $error("search length exceeds table depth");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(rd_v_ff || a_v_ff || b_v_ff))
      else $error("scoring pipeline busy while taking a new word");

   a_empty_ids: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wnss_pkg::S_DONE && out_free && !have_ff)
      |=> (rsp_valid_ff && rsp_data_ff.best_pose == 16'd0 && rsp_data_ff.best_anim == 16'd0))
      else $error("empty search returned nonzero ids");
`endif

endmodule

// ===== src/wnss_ram.sv =====
module wnss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== verif/tb_weighted_nearest_sample_search.sv =====
`timescale 1ns / 1ps

module tb_weighted_nearest_sample_search;
   import wnss_pkg::*;

   localparam int WORD_TARGET   = 850;
   localparam int SETTLE_CYCLES = 80;
   localparam int STALL_LIMIT   = 2000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WEIGHT_W-1:0]  csr_wdata;

   weighted_nearest_sample_search uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block's registers and sample table
   logic [WEIGHT_W-1:0] speed_w;
   logic [WEIGHT_W-1:0] heading_w;
   logic [WEIGHT_W-1:0] flag_w;
   logic [USED_W-1:0]   used_n;
   feat_type            stored_feat [MAX_SLOTS];
   ids_type             stored_ids  [MAX_SLOTS];

   rsp_type             pending_matches [$];
   rsp_type             want;
   int                  words_sent;
   int                  results_seen;
   int                  bad_results;
   int                  idle_cycles = 0;
   bit                  req_no_gaps;
   bit                  rsp_no_gaps;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic feat_type feat_of(req_type w);
      feat_type f;
      f.speed   = w.speed;
      f.heading = w.heading;
      f.flags   = {w.saving, w.keeper, w.airborne, w.sprinting};
      return f;
   endfunction

   function automatic logic [35:0] match_score(feat_type q, feat_type s);
      logic [15:0] ds;
      logic [15:0] dh;
      logic [15:0] ah;
      logic [2:0]  cnt;
      logic [39:0] sum;
      ds  = (q.speed >= s.speed) ? q.speed - s.speed : s.speed - q.speed;
      dh  = q.heading - s.heading;
      // magnitude of the wrapped angle, 0x8000 stays 0x8000 (180 degrees)
      ah  = dh[15] ? (~dh + 16'd1) : dh;
      cnt = 3'($countones(q.flags ^ s.flags));
      sum = 40'(ds) * 40'(speed_w)
          + ((40'(ah) * 40'(heading_w)) >> 12)
          + ((40'(cnt) * 40'(flag_w)) << 3);
      return (sum > 40'h0F_FFFF_FFFF) ? 36'hF_FFFF_FFFF : sum[35:0];
   endfunction

   function automatic rsp_type predict_best_match(req_type q);
      rsp_type     r;
      feat_type    qf;
      logic [35:0] best;
      logic [35:0] sc;
      int          n;
      r    = '0;
      best = '0;
      qf   = feat_of(q);
      n    = (used_n > MAX_SLOTS) ? MAX_SLOTS : int'(used_n);
      for (int i = 0; i < n; i++) begin
         sc = match_score(qf, stored_feat[i]);
         // strictly smaller only, so ties keep the lower slot
         if (!r.found || sc < best) begin
            r.found     = 1'b1;
            best        = sc;
            r.best_pose = stored_ids[i].pose_id;
            r.best_anim = stored_ids[i].anim_id;
         end
      end
      return r;
   endfunction

   function automatic req_type make_load(logic [5:0] slot, logic [15:0] speed,
                                         logic [15:0] heading, logic [3:0] flags,
                                         logic [15:0] pose, logic [15:0] anim);
      req_type w;
      w.cmd       = CMD_LOAD;
      w.slot      = slot;
      w.speed     = speed;
      w.heading   = heading;
      w.sprinting = flags[0];
      w.airborne  = flags[1];
      w.keeper    = flags[2];
      w.saving    = flags[3];
      w.pose_id   = pose;
      w.anim_id   = anim;
      return w;
   endfunction

   // slot and ids are don't-care for a query; fill them with noise
   function automatic req_type make_query(logic [15:0] speed, logic [15:0] heading,
                                          logic [3:0] flags);
      req_type w;
      w     = make_load(6'($urandom), speed, heading, flags, 16'($urandom),
                        16'($urandom));
      w.cmd = CMD_QUERY;
      return w;
   endfunction

   task automatic send_word(input req_type w);
      int unsigned gap;
      gap = req_no_gaps ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (w.cmd == CMD_LOAD) begin
         stored_feat[w.slot]        = feat_of(w);
         stored_ids[w.slot].pose_id = w.pose_id;
         stored_ids[w.slot].anim_id = w.anim_id;
      end else begin
         pending_matches.push_back(predict_best_match(w));
      end
   endtask

   // drop valid, drain all results, then give a trailing load time to finish
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SPEED_WEIGHT:   speed_w   = val;
         CSR_HEADING_WEIGHT: heading_w = val;
         CSR_FLAG_WEIGHT:    flag_w    = val;
         CSR_USED_SLOTS:     used_n    = val[USED_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [WEIGHT_W-1:0] sw, input logic [WEIGHT_W-1:0] hw,
                            input logic [WEIGHT_W-1:0] fw, input logic [USED_W-1:0] us);
      settle();
      write_reg(CSR_SPEED_WEIGHT, sw);
      write_reg(CSR_HEADING_WEIGHT, hw);
      write_reg(CSR_FLAG_WEIGHT, fw);
      write_reg(CSR_USED_SLOTS, {{(WEIGHT_W-USED_W){1'b0}}, us});
   endtask

   function automatic logic [15:0] pick_speed();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(0, 15));
         2:       return 16'hFFFF - 16'($urandom_range(0, 15));
         default: return 16'($urandom_range(0, 2047));
      endcase
   endfunction

   function automatic logic [15:0] pick_heading();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(0, 31));
         2:       return 16'h8000 + 16'($urandom_range(0, 31)) - 16'd16;
         default: return 16'hFFFF - 16'($urandom_range(0, 31));
      endcase
   endfunction

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return 16'd256;
         3:       return 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [USED_W-1:0] pick_used();
      case ($urandom_range(0, 7))
         0:       return 7'd0;
         1:       return 7'd1;
         2:       return 7'd63 + 7'($urandom_range(0, 2));
         3:       return 7'd127;
         4:       return 7'($urandom_range(65, 127));
         5:       return 7'($urandom_range(1, 16));
         default: return 7'($urandom_range(0, 64));
      endcase
   endfunction

   // ---------------- tests ----------------

   task automatic test_empty_table();
      // used_slots resets to 0: nothing to search
      send_word(make_query(16'hFFFF, 16'h8000, 4'hF));
   endtask

   task automatic test_load_and_tie();
      send_word(make_load(6'd0, 16'h0000, 16'h0000, 4'h0, 16'h0000, 16'hFFFF));
      send_word(make_load(6'd1, 16'hFFFF, 16'h8000, 4'hF, 16'hFFFF, 16'h0000));
      send_word(make_load(6'd2, 16'h0000, 16'h0000, 4'h0, 16'h5A5A, 16'hA5A5));
      send_word(make_load(6'd3, 16'h1234, 16'hFFFF, 4'h5, 16'h0003, 16'h0303));
      send_word(make_load(6'd63, 16'hAAAA, 16'h5555, 4'hA, 16'h3F3F, 16'hC0C0));
      settle();
      // reset weights still in effect here
      write_reg(CSR_USED_SLOTS, 16'd4);
      send_word(make_query(16'h0000, 16'h0000, 4'h0));
      send_word(make_query(16'hFFFF, 16'h8000, 4'hF));
      send_word(make_query(16'h1230, 16'hFFF0, 4'h5));
   endtask

   task automatic test_heading_wrap();
      configure(16'd0, 16'hFFFF, 16'd0, 7'd4);
      send_word(make_query(16'h7777, 16'h0001, 4'h3));
      send_word(make_query(16'h7777, 16'hFFFE, 4'hC));
      send_word(make_query(16'h0000, 16'h4000, 4'h0));
      send_word(make_query(16'h0000, 16'h4001, 4'h0));
   endtask

   task automatic test_weight_extremes();
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd4);
      send_word(make_query(16'hFFFF, 16'h8000, 4'hF));
      send_word(make_query(16'h8000, 16'h4000, 4'h5));
      send_word(make_query(16'h0000, 16'h7FFF, 4'hA));
      // all weights zero: every score ties, first slot wins
      configure(16'd0, 16'd0, 16'd0, 7'd4);
      send_word(make_query(16'hFFFF, 16'h8000, 4'hF));
      configure(16'd256, 16'd256, 16'd128, 7'd0);
      send_word(make_query(16'h0000, 16'h0000, 4'h0));
   endtask

   task automatic test_fill_table();
      req_no_gaps = 1'b0;
      rsp_no_gaps = 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++)
         send_word(make_load(6'(i), pick_speed(), pick_heading(), 4'($urandom),
                             16'($urandom), 16'($urandom)));
   endtask

   task automatic test_slot_count_limit();
      configure(16'd256, 16'd256, 16'd128, 7'd64);
      send_word(make_query(pick_speed(), pick_heading(), 4'($urandom)));
      configure(16'd256, 16'd256, 16'd128, 7'd65);
      send_word(make_query(pick_speed(), pick_heading(), 4'($urandom)));
      configure(16'd256, 16'd256, 16'd128, 7'd127);
      send_word(make_query(pick_speed(), pick_heading(), 4'($urandom)));
   endtask

   task automatic test_random_traffic();
      int unsigned len;
      int          idx;
      int          fb;
      logic [15:0] sp;
      logic [15:0] hd;
      logic [3:0]  fl;
      while (words_sent < WORD_TARGET) begin
         configure(pick_weight(), pick_weight(), pick_weight(), pick_used());
         req_no_gaps = ($urandom_range(0, 3) == 0);
         rsp_no_gaps = ($urandom_range(0, 3) == 0);
         len = $urandom_range(15, 40);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 35) begin
               send_word(make_load(6'($urandom), pick_speed(), pick_heading(),
                                   4'($urandom), 16'($urandom), 16'($urandom)));
            end else if ($urandom_range(0, 9) < 6) begin
               // close to a stored sample, so near-ties show up
               idx = $urandom_range(0, MAX_SLOTS - 1);
               sp  = stored_feat[idx].speed + 16'($urandom_range(0, 4)) - 16'd2;
               hd  = stored_feat[idx].heading + 16'($urandom_range(0, 8)) - 16'd4;
               fl  = stored_feat[idx].flags;
               if ($urandom_range(0, 1) == 1) begin
                  fb     = $urandom_range(0, 3);
                  fl[fb] = ~fl[fb];
               end
               send_word(make_query(sp, hd, fl));
            end else begin
               send_word(make_query(pick_speed(), pick_heading(), 4'($urandom)));
            end
         end
      end
   endtask

   // ---------------- result side ----------------

   initial begin : rsp_stall_proc
      int unsigned gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = rsp_no_gaps ? 0 : $urandom_range(0, 11);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_matches.size() == 0) begin
            bad_results++;
            if (bad_results <= 10)
               $display("ERROR: unexpected result word %0d: found=%0b pose=%h anim=%h",
                        results_seen, rsp_data.found, rsp_data.best_pose, rsp_data.best_anim);
         end else begin
            want = pending_matches.pop_front();
            if (rsp_data.found !== want.found || rsp_data.best_pose !== want.best_pose ||
                rsp_data.best_anim !== want.best_anim) begin
               bad_results++;
               if (bad_results <= 10)
                  $display("ERROR: result word %0d expected found=%0b pose=%h anim=%h, got found=%0b pose=%h anim=%h",
                           results_seen, want.found, want.best_pose, want.best_anim,
                           rsp_data.found, rsp_data.best_pose, rsp_data.best_anim);
            end
         end
      end
   end

   // cycles without any word moving on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_we      <= 1'b0;
      csr_index   <= CSR_SPEED_WEIGHT;
      csr_wdata   <= '0;
      speed_w      = SPEED_WEIGHT_RST;
      heading_w    = HEADING_WEIGHT_RST;
      flag_w       = FLAG_WEIGHT_RST;
      used_n       = USED_SLOTS_RST;
      words_sent   = 0;
      results_seen = 0;
      bad_results  = 0;
      req_no_gaps  = 1'b0;
      rsp_no_gaps  = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_load_and_tie();
      test_heading_wrap();
      test_weight_extremes();
      test_fill_table();
      test_slot_count_limit();
      test_random_traffic();
      settle();

      if (bad_results == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
